/* rtl/assert_macros.svh */
// Assertion macros for the interpolator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define STLI_ASSERT(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define STLI_NEVER(lbl, clk, rstn, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define STLI_ASSERT(lbl, clk, rstn, prop, msg)
`define STLI_NEVER(lbl, clk, rstn, cond, msg)
`endif
`endif

/* rtl/stli_pkg.sv */
// Shared types and constants of the sorted table linear interpolator.
package stli_pkg;

	localparam int INDEX_WIDTH  = 8;
	localparam int SEG_WIDTH    = 8;
	localparam int STATUS_WIDTH = 3;
	localparam int CFG_WIDTH    = 9;
	localparam int MUL_DIGIT    = 16;

	localparam logic MODE_LOAD  = 1'b0;
	localparam logic MODE_QUERY = 1'b1;

	localparam logic [STATUS_WIDTH-1:0] ST_OK     = 3'd0;
	localparam logic [STATUS_WIDTH-1:0] ST_BELOW  = 3'd1;
	localparam logic [STATUS_WIDTH-1:0] ST_ABOVE  = 3'd2;
	localparam logic [STATUS_WIDTH-1:0] ST_UNORD  = 3'd3;
	localparam logic [STATUS_WIDTH-1:0] ST_ZWIDTH = 3'd4;
	localparam logic [STATUS_WIDTH-1:0] ST_SAT    = 3'd5;
	localparam logic [STATUS_WIDTH-1:0] ST_SINGLE = 3'd6;

	localparam logic [1:0] RES_ZERO   = 2'd0;
	localparam logic [1:0] RES_Y0     = 2'd1;
	localparam logic [1:0] RES_INTERP = 2'd2;

	typedef struct packed {
		logic                    we;
		logic                    cap_x;
		logic                    ld_lo;
		logic                    ld_hi;
		logic                    ld_a;
		logic                    ld_diff;
		logic                    mul_step;
		logic                    div_step;
		logic                    out_load;
		logic [1:0]              res_sel;
		logic [STATUS_WIDTH-1:0] code;
		logic [SEG_WIDTH-1:0]    seg;
	} stli_cmd_t;

	typedef struct packed {
		logic x_lt_lo;
		logic x_lt_rd;
		logic x_gt_rd;
		logic x_lt_hi;
		logic zero_width;
	} stli_stat_t;

endpackage

/* rtl/sorted_table_linear_interpolator_top.sv */
// Top level of the sorted table linear interpolator.
// Usage:
//   Slave stream carries load and query beats; tuser selects the kind (0 load, 1 query).
//   A load beat writes one (x, y) breakpoint pair at entry_index if it is below MAX_POINTS; it gives no result.
//   A query beat binary-searches the table, interpolates and returns one master beat
//   with y_result and segment in tdata and the status code in tuser.
//   cfg_we/cfg_wdata set the number of points in use; write only while idle.
//   A query runs a search of up to ceil(log2(points-1)) steps, none when extrapolating,
//   each step going through the single table read port; then a serial multiply in
//   16 bit digits and a 2 bit per cycle divider over the 2*VALUE_WIDTH bit product.
//   A zero-width segment skips multiply and divide. Empty and single point tables
//   answer without a search.
//   One query is in flight at a time; s_tready is high only while the sequencer is idle,
//   so the next beat can be taken in the cycle after the result loads.
//   The result sits in an output register, so the next beat is taken while it waits;
//   a stalled receiver holds the finished next result until that register frees.
//   Reset clears the point count to zero and the handshake state; table contents
//   stay undefined until loaded.
module sorted_table_linear_interpolator_top #(
	parameter int MAX_POINTS  = 256,
	parameter int VALUE_WIDTH = 32,
	localparam int IN_TDW  = ((2*VALUE_WIDTH + stli_pkg::INDEX_WIDTH + 7) / 8) * 8,
	localparam int OUT_TDW = ((VALUE_WIDTH + stli_pkg::SEG_WIDTH + 7) / 8) * 8
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [IN_TDW-1:0]                  s_tdata,  // entry_index, x_value, y_value
	input  logic                               s_tuser,  // mode
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [OUT_TDW-1:0]                 m_tdata,  // y_result, segment
	output logic [stli_pkg::STATUS_WIDTH-1:0]  m_tuser,  // status
	input  logic                               cfg_we,
	input  logic [stli_pkg::CFG_WIDTH-1:0]     cfg_wdata
);

	localparam int VW = VALUE_WIDTH;
	localparam int IW = stli_pkg::INDEX_WIDTH;
	localparam int AW = $clog2(MAX_POINTS);

	stli_pkg::stli_cmd_t                cmd;
	stli_pkg::stli_stat_t               stat;
	logic [AW-1:0]                      raddr;
	logic [VW-1:0]                      y_result;
	logic [stli_pkg::SEG_WIDTH-1:0]     segment;
	logic [stli_pkg::STATUS_WIDTH-1:0]  status;

	stli_ctrl #(
		.MAX_POINTS (MAX_POINTS),
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.mode       (s_tuser),
		.entry_index(s_tdata[IW-1:0]),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.stat       (stat),
		.cmd        (cmd),
		.raddr      (raddr)
	);

	stli_dp #(
		.MAX_POINTS (MAX_POINTS),
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_dp (
		.clk        (clk),
		.cmd        (cmd),
		.raddr      (raddr),
		.entry_index(s_tdata[IW-1:0]),
		.wdata      (s_tdata[2*VW+IW-1:IW]),
		.x_value    (s_tdata[VW+IW-1:IW]),
		.stat       (stat),
		.y_result   (y_result),
		.segment    (segment),
		.status     (status)
	);

	assign m_tdata = OUT_TDW'({segment, y_result});
	assign m_tuser = status;

endmodule

/* rtl/stli_ram.sv */
// Generic single write port, single read port RAM with registered read.
module stli_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 256,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

/* rtl/stli_dp.sv */
// Datapath: breakpoint table, search compares, serial multiply and divide, result.
module stli_dp #(
	parameter int MAX_POINTS  = 256,
	parameter int VALUE_WIDTH = 32,
	localparam int AW = $clog2(MAX_POINTS)
) (
	input  logic                                   clk,
	input  stli_pkg::stli_cmd_t                    cmd,
	input  logic [AW-1:0]                          raddr,
	input  logic [stli_pkg::INDEX_WIDTH-1:0]       entry_index,
	input  logic [2*VALUE_WIDTH-1:0]               wdata,
	input  logic [VALUE_WIDTH-1:0]                 x_value,
	output stli_pkg::stli_stat_t                   stat,
	output logic [VALUE_WIDTH-1:0]                 y_result,
	output logic [stli_pkg::SEG_WIDTH-1:0]         segment,
	output logic [stli_pkg::STATUS_WIDTH-1:0]      status
);

	localparam int VW = VALUE_WIDTH;
	localparam int DG = stli_pkg::MUL_DIGIT;
	localparam int MUL_STEPS = (VW + DG - 1) / DG;
	localparam int BW = MUL_STEPS * DG;
	localparam int PW = VW + DG;
	localparam logic [VW-1:0] VMAX = {1'b0, {(VW-1){1'b1}}};
	localparam logic [VW-1:0] VMIN = {1'b1, {(VW-1){1'b0}}};

	logic [2*VW-1:0] rdata;
	logic signed [VW-1:0] rd_x, rd_y;

	logic signed [VW-1:0] x_q, xlo_q, xhi_q, xa_q, ya_q;
	logic [VW-1:0]   a_q, d_q, rem_q;
	logic [BW-1:0]   b_q;
	logic [2*VW-1:0] prod_q;
	logic            neg_q;

	logic [VW-1:0]                     y_out_q;
	logic [stli_pkg::SEG_WIDTH-1:0]    seg_out_q;
	logic [stli_pkg::STATUS_WIDTH-1:0] st_out_q;

	logic [VW:0]     dy_w, dxq_w, dx_w;
	logic [PW-1:0]   pp;
	logic [VW-1:0]   r1, r2;
	logic            q1, q0;
	logic            ovf, sat, dir_neg;
	logic [VW+1:0]   qext, yext, sum;
	logic [VW-1:0]   interp_y;

	stli_ram #(
		.WIDTH(2*VW),
		.DEPTH(MAX_POINTS)
	) u_table (
		.clk  (clk),
		.we   (cmd.we),
		.waddr(AW'(entry_index)),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	assign rd_x = rdata[VW-1:0];
	assign rd_y = rdata[2*VW-1:VW];

	function automatic logic [VW-1:0] mag_of(input logic [VW:0] v);
		logic [VW:0] m;
		m = v[VW] ? ((VW+1)'(0) - v) : v;
		return m[VW-1:0];
	endfunction

	// one restoring division bit
	function automatic logic [VW:0] div_bit(input logic [VW-1:0] r, input logic b,
			input logic [VW-1:0] d);
		logic [VW:0] t;
		logic [VW:0] s;
		t = {r, b};
		s = t - {1'b0, d};
		if (t >= {1'b0, d}) begin
			return {1'b1, s[VW-1:0]};
		end
		return {1'b0, t[VW-1:0]};
	endfunction

	always_comb begin
		stat.x_lt_lo    = x_q < xlo_q;
		stat.x_lt_rd    = x_q < rd_x;
		stat.x_gt_rd    = x_q > rd_x;
		stat.x_lt_hi    = x_q < xhi_q;
		stat.zero_width = rd_x == xa_q;
	end

	always_comb begin
		dy_w  = {rd_y[VW-1], rd_y} - {ya_q[VW-1], ya_q};
		dxq_w = {x_q[VW-1], x_q} - {xa_q[VW-1], xa_q};
		dx_w  = {rd_x[VW-1], rd_x} - {xa_q[VW-1], xa_q};
		pp    = a_q * b_q[BW-1 -: DG];
		{q1, r1} = div_bit(rem_q, prod_q[2*VW-1], d_q);
		{q0, r2} = div_bit(r1, prod_q[2*VW-2], d_q);
	end

	always_comb begin
		ovf     = |prod_q[2*VW-1:VW];
		qext    = {2'b00, prod_q[VW-1:0]};
		yext    = {{2{ya_q[VW-1]}}, ya_q};
		sum     = neg_q ? (yext - qext) : (yext + qext);
		sat     = ovf || !((sum[VW+1:VW-1] == 3'b000) || (sum[VW+1:VW-1] == 3'b111));
		dir_neg = ovf ? neg_q : sum[VW+1];
		interp_y = sat ? (dir_neg ? VMIN : VMAX) : sum[VW-1:0];
	end

	always_ff @(posedge clk) begin
		if (cmd.cap_x) begin
			x_q <= x_value;
		end
		if (cmd.ld_lo) begin
			xlo_q <= rd_x;
		end
		if (cmd.ld_hi) begin
			xhi_q <= rd_x;
		end
		if (cmd.ld_a) begin
			xa_q <= rd_x;
			ya_q <= rd_y;
		end
		if (cmd.ld_diff) begin
			a_q    <= mag_of(dy_w);
			b_q    <= BW'(mag_of(dxq_w));
			d_q    <= mag_of(dx_w);
			neg_q  <= dy_w[VW] ^ dxq_w[VW] ^ dx_w[VW];
			prod_q <= '0;
			rem_q  <= '0;
		end
		if (cmd.mul_step) begin
			prod_q <= (prod_q << DG) + (2*VW)'(pp);
			b_q    <= b_q << DG;
		end
		if (cmd.div_step) begin
			prod_q <= {prod_q[2*VW-3:0], q1, q0};
			rem_q  <= r2;
		end
		if (cmd.out_load) begin
			seg_out_q <= cmd.seg;
			case (cmd.res_sel)
				stli_pkg::RES_ZERO: begin
					y_out_q  <= '0;
					st_out_q <= cmd.code;
				end
				stli_pkg::RES_Y0: begin
					y_out_q  <= ya_q;
					st_out_q <= cmd.code;
				end
				stli_pkg::RES_INTERP: begin
					y_out_q  <= interp_y;
					st_out_q <= sat ? stli_pkg::ST_SAT : cmd.code;
				end
				default: begin
					y_out_q  <= '0;
					st_out_q <= cmd.code;
				end
			endcase
		end
	end

	assign y_result = y_out_q;
	assign segment  = seg_out_q;
	assign status   = st_out_q;

endmodule

/* rtl/stli_ctrl.sv */
// Controller: handshakes, table search sequencing, multiply/divide step count.
`include "assert_macros.svh"

module stli_ctrl #(
	parameter int MAX_POINTS  = 256,
	parameter int VALUE_WIDTH = 32,
	localparam int AW = $clog2(MAX_POINTS)
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic                               mode,
	input  logic [stli_pkg::INDEX_WIDTH-1:0]   entry_index,
	input  logic                               cfg_we,
	input  logic [stli_pkg::CFG_WIDTH-1:0]     cfg_wdata,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	input  stli_pkg::stli_stat_t               stat,
	output stli_pkg::stli_cmd_t                cmd,
	output logic [AW-1:0]                      raddr
);

	localparam int NW = ($clog2(MAX_POINTS + 1) > stli_pkg::CFG_WIDTH) ?
		$clog2(MAX_POINTS + 1) : stli_pkg::CFG_WIDTH;
	localparam int MUL_STEPS = (VALUE_WIDTH + stli_pkg::MUL_DIGIT - 1) / stli_pkg::MUL_DIGIT;
	localparam int CNTW = $clog2(VALUE_WIDTH);
	localparam logic [CNTW-1:0] MUL_LAST = CNTW'(MUL_STEPS - 1);
	localparam logic [CNTW-1:0] DIV_LAST = CNTW'(VALUE_WIDTH - 1);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_FIRST = 4'd1;
	localparam logic [3:0] S_LAST  = 4'd2;
	localparam logic [3:0] S_MID   = 4'd3;
	localparam logic [3:0] S_CMP   = 4'd4;
	localparam logic [3:0] S_SEGA  = 4'd5;
	localparam logic [3:0] S_SEGB  = 4'd6;
	localparam logic [3:0] S_DIFF  = 4'd7;
	localparam logic [3:0] S_MUL   = 4'd8;
	localparam logic [3:0] S_DIV   = 4'd9;
	localparam logic [3:0] S_DONE  = 4'd10;

	logic [3:0]                        state_q, state_n;
	logic [stli_pkg::CFG_WIDTH-1:0]    point_count_q;
	logic [NW-1:0]                     n_q, n_n, n_cfg;
	logic [AW-1:0]                     lo_q, lo_n, hi_q, hi_n, mid_q, mid_n, seg_q, seg_n;
	logic [AW:0]                       mid_sum;
	logic [1:0]                        res_q, res_n;
	logic [stli_pkg::STATUS_WIDTH-1:0] code_q, code_n;
	logic [CNTW-1:0]                   cnt_q, cnt_n;
	logic                              out_valid_q;
	logic                              accept, idx_ok, bad;

	function automatic logic more_steps(input logic [AW-1:0] l, input logic [AW-1:0] h);
		return ({1'b0, l} + (AW+1)'(1)) < {1'b0, h};
	endfunction

	assign s_tready = state_q == S_IDLE;
	assign m_tvalid = out_valid_q;
	assign accept   = s_tvalid && s_tready;
	assign idx_ok   = NW'(entry_index) < NW'(MAX_POINTS);
	assign n_cfg    = (NW'(point_count_q) > NW'(MAX_POINTS)) ? NW'(MAX_POINTS) :
		NW'(point_count_q);
	assign mid_sum  = {1'b0, lo_q} + {1'b0, hi_q};

	always_comb begin
		cmd     = '0;
		raddr   = '0;
		state_n = state_q;
		n_n     = n_q;
		lo_n    = lo_q;
		hi_n    = hi_q;
		mid_n   = mid_q;
		seg_n   = seg_q;
		res_n   = res_q;
		code_n  = code_q;
		cnt_n   = cnt_q;
		bad     = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (mode == stli_pkg::MODE_LOAD) begin
						cmd.we = idx_ok;
					end else begin
						cmd.cap_x = 1'b1;
						n_n       = n_cfg;
						seg_n     = '0;
						if (n_cfg == '0) begin
							res_n   = stli_pkg::RES_ZERO;
							code_n  = stli_pkg::ST_OK;
							state_n = S_DONE;
						end else begin
							state_n = S_FIRST;
						end
					end
				end
			end
			S_FIRST: begin
				cmd.ld_lo = 1'b1;
				cmd.ld_a  = 1'b1;
				lo_n      = '0;
				hi_n      = AW'(n_q - NW'(1));
				if (n_q == NW'(1)) begin
					res_n   = stli_pkg::RES_Y0;
					code_n  = stli_pkg::ST_SINGLE;
					state_n = S_DONE;
				end else begin
					raddr   = AW'(n_q - NW'(1));
					state_n = S_LAST;
				end
			end
			S_LAST: begin
				cmd.ld_hi = 1'b1;
				state_n   = S_SEGA;
				if (stat.x_lt_lo) begin
					seg_n  = '0;
					code_n = stli_pkg::ST_BELOW;
				end else if (!stat.x_lt_rd) begin
					seg_n  = hi_q - AW'(1);
					code_n = stat.x_gt_rd ? stli_pkg::ST_ABOVE : stli_pkg::ST_OK;
				end else begin
					code_n = stli_pkg::ST_OK;
					if (more_steps(lo_q, hi_q)) begin
						state_n = S_MID;
					end else begin
						seg_n = lo_q;
					end
				end
			end
			S_MID: begin
				mid_n   = mid_sum[AW:1];
				raddr   = mid_sum[AW:1];
				state_n = S_CMP;
			end
			S_CMP: begin
				if (!stat.x_lt_lo && stat.x_lt_rd) begin
					cmd.ld_hi = 1'b1;
					hi_n      = mid_q;
				end else if (!stat.x_lt_rd && stat.x_lt_hi) begin
					cmd.ld_lo = 1'b1;
					lo_n      = mid_q;
				end else begin
					bad = 1'b1;
				end
				if (bad) begin
					seg_n   = '0;
					res_n   = stli_pkg::RES_ZERO;
					code_n  = stli_pkg::ST_UNORD;
					state_n = S_DONE;
				end else if (more_steps(lo_n, hi_n)) begin
					state_n = S_MID;
				end else begin
					seg_n   = lo_n;
					state_n = S_SEGA;
				end
			end
			S_SEGA: begin
				raddr   = seg_q;
				state_n = S_SEGB;
			end
			S_SEGB: begin
				cmd.ld_a = 1'b1;
				raddr    = seg_q + AW'(1);
				state_n  = S_DIFF;
			end
			S_DIFF: begin
				cmd.ld_diff = 1'b1;
				cnt_n       = '0;
				if (stat.zero_width) begin
					res_n   = stli_pkg::RES_ZERO;
					code_n  = stli_pkg::ST_ZWIDTH;
					state_n = S_DONE;
				end else begin
					state_n = S_MUL;
				end
			end
			S_MUL: begin
				cmd.mul_step = 1'b1;
				if (cnt_q == MUL_LAST) begin
					cnt_n   = '0;
					state_n = S_DIV;
				end else begin
					cnt_n = cnt_q + CNTW'(1);
				end
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (cnt_q == DIV_LAST) begin
					res_n   = stli_pkg::RES_INTERP;
					state_n = S_DONE;
				end else begin
					cnt_n = cnt_q + CNTW'(1);
				end
			end
			S_DONE: begin
				cmd.res_sel = res_q;
				cmd.code    = code_q;
				cmd.seg     = stli_pkg::SEG_WIDTH'(seg_q);
				if (!out_valid_q || m_tready) begin
					cmd.out_load = 1'b1;
					state_n      = S_IDLE;
				end
			end
			default: begin
				state_n = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			point_count_q <= '0;
			out_valid_q   <= 1'b0;
			n_q           <= '0;
			lo_q          <= '0;
			hi_q          <= '0;
			mid_q         <= '0;
			seg_q         <= '0;
			res_q         <= stli_pkg::RES_ZERO;
			code_q        <= stli_pkg::ST_OK;
			cnt_q         <= '0;
		end else begin
			state_q <= state_n;
			n_q     <= n_n;
			lo_q    <= lo_n;
			hi_q    <= hi_n;
			mid_q   <= mid_n;
			seg_q   <= seg_n;
			res_q   <= res_n;
			code_q  <= code_n;
			cnt_q   <= cnt_n;
			if (cfg_we) begin
				point_count_q <= cfg_wdata;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	`STLI_NEVER(a_no_overwrite, clk, arst_n, cmd.out_load && out_valid_q && !m_tready, "result beat overwritten while stalled")
	`STLI_NEVER(a_search_order, clk, arst_n, ((state_q == S_MID) || (state_q == S_CMP)) && !(lo_q < hi_q), "search bounds crossed")
	`STLI_ASSERT(a_seg_range, clk, arst_n, (state_q == S_SEGA) |-> ((NW'(seg_q) + NW'(1)) < n_q), "segment upper point outside table")

endmodule
